### rtl/core/lora_time_on_air_core_assert.svh
// Assertion macros used by the checker file.
`ifndef LORA_TIME_ON_AIR_CORE_ASSERT_SVH
`define LORA_TIME_ON_AIR_CORE_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define LTOA_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define LTOA_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/ltoa_pkg.sv
`timescale 1ns / 1ps
package ltoa_pkg;
   localparam int unsigned REQ_DATA_W = 8;
   localparam int unsigned RSP_DATA_W = 24;
   localparam int unsigned AIRTIME_W = 19;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W = 19;

   localparam logic [CSR_INDEX_W-1:0] REG_SPREAD_FACTOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CODE_RATE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_BANDWIDTH = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_PREAMBLE = 2'd3;

   localparam logic [3:0] SF_MIN = 4'd6;
   localparam logic [3:0] SF_MAX = 4'd12;
   localparam logic [11:0] HDR_CRC_ROUND = 12'd43;
   localparam logic [9:0] MILLI = 10'd1000;
   localparam logic [12:0] PRE_EXTRA_MILLI = 13'd4250;
   localparam logic [AIRTIME_W-1:0] AIRTIME_MAX = 19'd524287;

   localparam int unsigned SYM_NUM_W = 12;
   localparam int unsigned SYM_DEN_W = 6;
   localparam int unsigned AIR_NUM_W = 33;
   localparam int unsigned AIR_DEN_W = 19;
   localparam int unsigned STAGES = 4 + SYM_NUM_W + AIR_NUM_W;
endpackage

### rtl/core/lora_time_on_air_core.sv
`timescale 1ns / 1ps
// Channel   | Direction | Contents
// req_      | in        | tdata[7:0] payload_length
// rsp_      | out       | tdata[18:0] airtime_ms
// csr_      | in        | index 0..3, data: spread factor, code rate, bandwidth, preamble
// A result is shown at rsp_ once its item has passed the whole pipeline; one item enters
// per cycle unless a result stalled at rsp_ holds it. The pipeline is two chains of division cells,
// 12 for the symbol count and 33 for the division by bandwidth, plus four arithmetic stages.
// Reset is synchronous; it empties the pipeline and restores register defaults.
// A result waiting at rsp_ freezes the whole pipeline until it is taken.
module lora_time_on_air_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [ltoa_pkg::REQ_DATA_W-1:0]        req_tdata,   // [7:0] payload_length
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [ltoa_pkg::RSP_DATA_W-1:0]        rsp_tdata,   // [18:0] airtime_ms
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [ltoa_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [ltoa_pkg::CSR_DATA_W-1:0]        csr_data
);
   localparam int unsigned SW = ltoa_pkg::SYM_DEN_W + ltoa_pkg::SYM_NUM_W;
   localparam int unsigned AW = ltoa_pkg::AIR_DEN_W + ltoa_pkg::AIR_NUM_W;

   logic [3:0]  sf_ff;
   logic [3:0]  cr_ff;
   logic [18:0] bw_ff;
   logic [7:0]  pre_ff;
   logic [3:0]  sf_eff;
   logic        en;

   logic [ltoa_pkg::STAGES-1:0] vld_ff;
   logic [ltoa_pkg::STAGES-1:0] vld_in;
   logic        rsp_valid_ff;
   logic [18:0] rsp_data_ff;
   logic [18:0] rsp_data_in;

   logic [11:0] x_ff;
   logic [10:0] sym_ff;
   logic [20:0] pay_m_ff;
   logic [17:0] pre_m_ff;
   logic [32:0] pay_n_ff;
   logic [32:0] pre_n_ff;
   logic [33:0] total;

   logic [SW-1:0] sw [0:ltoa_pkg::SYM_NUM_W];
   logic [AW-1:0] pay_w [0:ltoa_pkg::AIR_NUM_W];
   logic [AW-1:0] pre_w [0:ltoa_pkg::AIR_NUM_W];

   assign en = !(rsp_valid_ff && !rsp_tready);
   assign req_tready = en;
   assign csr_ready = 1'b1;

   always_comb begin
      if (sf_ff < ltoa_pkg::SF_MIN) begin
         sf_eff = ltoa_pkg::SF_MIN;
      end else if (sf_ff > ltoa_pkg::SF_MAX) begin
         sf_eff = ltoa_pkg::SF_MAX;
      end else begin
         sf_eff = sf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sf_ff  <= 4'd9;
         cr_ff  <= 4'd6;
         bw_ff  <= 19'd125000;
         pre_ff <= 8'd8;
      end else if (csr_valid) begin
         unique case (csr_index)
            ltoa_pkg::REG_SPREAD_FACTOR: sf_ff  <= csr_data[3:0];
            ltoa_pkg::REG_CODE_RATE:     cr_ff  <= csr_data[3:0];
            ltoa_pkg::REG_BANDWIDTH:     bw_ff  <= csr_data;
            ltoa_pkg::REG_PREAMBLE:      pre_ff <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   assign vld_in = {vld_ff[ltoa_pkg::STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= vld_in;
         rsp_valid_ff <= vld_ff[ltoa_pkg::STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff     <= {1'b0, req_tdata[7:0], 3'b000} + ltoa_pkg::HDR_CRC_ROUND;
         sym_ff   <= 11'(cr_ff * sw[ltoa_pkg::SYM_NUM_W][6:0]) + 11'd8;
         pay_m_ff <= 21'(sym_ff * ltoa_pkg::MILLI);
         pre_m_ff <= 18'(pre_ff * ltoa_pkg::MILLI) + 18'(ltoa_pkg::PRE_EXTRA_MILLI);
         pay_n_ff <= {12'b0, pay_m_ff} << sf_eff;
         pre_n_ff <= {15'b0, pre_m_ff} << sf_eff;
      end
   end

   assign sw[0] = {{ltoa_pkg::SYM_DEN_W{1'b0}}, x_ff};

   genvar gi;
   generate
      for (gi = 0; gi < ltoa_pkg::SYM_NUM_W; gi++) begin : g_sym
         ltoa_div_cell #(
            .NUM_W(ltoa_pkg::SYM_NUM_W),
            .DEN_W(ltoa_pkg::SYM_DEN_W)
         ) u_cell (
            .clock (clock),
            .en    (en),
            .den   ({sf_eff, 2'b00}),
            .word_i(sw[gi]),
            .word_o(sw[gi+1])
         );
      end
   endgenerate

   assign pay_w[0] = {{ltoa_pkg::AIR_DEN_W{1'b0}}, pay_n_ff};
   assign pre_w[0] = {{ltoa_pkg::AIR_DEN_W{1'b0}}, pre_n_ff};

   generate
      for (gi = 0; gi < ltoa_pkg::AIR_NUM_W; gi++) begin : g_air
         ltoa_div_cell #(
            .NUM_W(ltoa_pkg::AIR_NUM_W),
            .DEN_W(ltoa_pkg::AIR_DEN_W)
         ) u_pay (
            .clock (clock),
            .en    (en),
            .den   (bw_ff),
            .word_i(pay_w[gi]),
            .word_o(pay_w[gi+1])
         );
         ltoa_div_cell #(
            .NUM_W(ltoa_pkg::AIR_NUM_W),
            .DEN_W(ltoa_pkg::AIR_DEN_W)
         ) u_pre (
            .clock (clock),
            .en    (en),
            .den   (bw_ff),
            .word_i(pre_w[gi]),
            .word_o(pre_w[gi+1])
         );
      end
   endgenerate

   assign total = {1'b0, pay_w[ltoa_pkg::AIR_NUM_W][32:0]}
                + {1'b0, pre_w[ltoa_pkg::AIR_NUM_W][32:0]};

   always_comb begin
      if (bw_ff == '0 || total > 34'(ltoa_pkg::AIRTIME_MAX)) begin
         rsp_data_in = ltoa_pkg::AIRTIME_MAX;
      end else begin
         rsp_data_in = total[18:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};
endmodule

### rtl/core/ltoa_div_cell.sv
`timescale 1ns / 1ps
// One restoring division step: the word holds the partial remainder above the
// numerator bits, and quotient bits fill in from the bottom.
module ltoa_div_cell #(
   parameter int unsigned NUM_W = 12,
   parameter int unsigned DEN_W = 6
) (
   input  logic                     clock,
   input  logic                     en,
   input  logic [DEN_W-1:0]         den,
   input  logic [DEN_W+NUM_W-1:0]   word_i,
   output logic [DEN_W+NUM_W-1:0]   word_o
);
   logic [DEN_W+NUM_W-1:0] word_ff;
   logic [DEN_W+NUM_W-1:0] word_in;
   logic [DEN_W:0]         part;
   logic [DEN_W:0]         diff;

   assign part = word_i[DEN_W+NUM_W-1:NUM_W-1];
   assign diff = part - {1'b0, den};

   always_comb begin
      if (part >= {1'b0, den}) begin
         word_in = {diff[DEN_W-1:0], word_i[NUM_W-2:0], 1'b1};
      end else begin
         word_in = {word_i[DEN_W+NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign word_o = word_ff;
endmodule

### rtl/core/ltoa_checker.sv
`timescale 1ns / 1ps
`include "lora_time_on_air_core_assert.svh"
module ltoa_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [ltoa_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   `LTOA_ASSERT(a_reset_empties, clock, reset |=> !rsp_tvalid, "result after reset")
   `LTOA_ASSERT_RST(a_stall_blocks_input, clock, reset, (rsp_tvalid && !rsp_tready) |-> !req_tready, "input taken while result stalled")
   `LTOA_ASSERT_RST(a_valid_holds, clock, reset, (rsp_tvalid && !rsp_tready) |=> rsp_tvalid, "result dropped")
   `LTOA_ASSERT_RST(a_data_holds, clock, reset, (rsp_tvalid && !rsp_tready) |=> $stable(rsp_tdata), "result changed under stall")
endmodule

bind lora_time_on_air_core ltoa_checker u_ltoa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tvalid(req_tvalid),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata)
);

### dv/lora_time_on_air_core_tb.sv
`timescale 1ns / 1ps
module lora_time_on_air_core_tb;

   class airtime_scoreboard;
      logic [3:0] sf_reg;
      logic [3:0] cr_reg;
      logic [18:0] bw_reg;
      logic [7:0] pre_reg;
      logic [18:0] pending_airtime[$];
      int errors;

      function void restore_defaults();
         sf_reg = 4'd9;
         cr_reg = 4'd6;
         bw_reg = 19'd125000;
         pre_reg = 8'd8;
         errors = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [18:0] value);
         case (idx)
            ltoa_pkg::REG_SPREAD_FACTOR: sf_reg = value[3:0];
            ltoa_pkg::REG_CODE_RATE: cr_reg = value[3:0];
            ltoa_pkg::REG_BANDWIDTH: bw_reg = value;
            ltoa_pkg::REG_PREAMBLE: pre_reg = value[7:0];
            default: ;
         endcase
      endfunction

      function void note_request(logic [7:0] len_bytes);
         int sf;
         int num;
         int d;
         int q;
         int prod;
         longint unsigned chips;
         longint unsigned t_pre;
         longint unsigned t_pay;
         longint unsigned total;
         sf = sf_reg;
         if (sf < 6) sf = 6;
         if (sf > 12) sf = 12;
         num = 8 * int'(len_bytes) - 4 * sf + 44;
         d = 4 * sf;
         if (num > 0) q = (num + d - 1) / d;
         else q = -((-num) / d);
         prod = q * int'(cr_reg);
         if (prod < 0) prod = 0;
         if (bw_reg == 0) begin
            pending_airtime.push_back(19'h7FFFF);
            return;
         end
         chips = 64'd1 << sf;
         t_pre = ((64'd1000 * pre_reg + 64'd4250) * chips) / bw_reg;
         t_pay = (64'd1000 * (prod + 8) * chips) / bw_reg;
         total = t_pre + t_pay;
         if (total > 64'd524287) total = 64'd524287;
         pending_airtime.push_back(total[18:0]);
      endfunction

      function void check_response(logic [23:0] data);
         logic [18:0] want;
         if (pending_airtime.size() == 0) begin
            $error("airtime_ms: unexpected item, actual %0d", data[18:0]);
            errors++;
            return;
         end
         want = pending_airtime.pop_front();
         if (data[18:0] !== want) begin
            $error("airtime_ms: expected %0d, actual %0d", want, data[18:0]);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [7:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [23:0] rsp_tdata;
   logic csr_valid;
   logic csr_ready;
   logic [1:0] csr_index;
   logic [18:0] csr_data;
   int send_idle_pct;
   int recv_idle_pct;
   airtime_scoreboard board;

   lora_time_on_air_core dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("lora_time_on_air_core_tb: done, errors");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) board.check_response(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic write_csr(logic [1:0] idx, logic [18:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      board.write_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_length(logic [7:0] len_bytes);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= len_bytes;
      do @(posedge clock); while (!req_tready);
      board.note_request(len_bytes);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending_airtime.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic configure(int sf, int cr, int bw, int pre);
      write_csr(ltoa_pkg::REG_SPREAD_FACTOR, sf[18:0]);
      write_csr(ltoa_pkg::REG_CODE_RATE, cr[18:0]);
      write_csr(ltoa_pkg::REG_BANDWIDTH, bw[18:0]);
      write_csr(ltoa_pkg::REG_PREAMBLE, pre[18:0]);
   endtask

   task automatic random_config();
      int bws[10] = '{7800, 10400, 15600, 20800, 31250, 41700, 62500, 125000, 250000,
                      500000};
      int r;
      r = $urandom_range(9);
      configure($urandom_range(15), $urandom_range(15),
                (r == 9 && $urandom_range(3) == 0) ? $urandom_range(524287) : bws[r],
                $urandom_range(255));
   endtask

   initial begin
      int lengths[12] = '{0, 255, 1, 128, 127, 2, 3, 51, 64, 200, 170, 85};
      board = new();
      board.restore_defaults();
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      rsp_tready = 0;
      csr_valid = 0;
      csr_index = 0;
      csr_data = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (lengths[i]) send_length(lengths[i]);
      drain();
      configure(12, 8, 7800, 255);
      send_length(0);
      send_length(255);
      send_length(128);
      drain();
      configure(6, 5, 500000, 0);
      send_length(0);
      send_length(255);
      send_length(1);
      drain();
      configure(0, 0, 0, 170);
      send_length(85);
      send_length(255);
      drain();
      configure(15, 15, 524287, 85);
      send_length(0);
      send_length(255);
      drain();
      write_csr(ltoa_pkg::REG_BANDWIDTH, 19'd1);
      drain();
      send_length(255);
      drain();
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = (phase == 0) ? 6 : (phase == 1) ? 79 : 0;
         recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 6 : 0;
         for (int blk = 0; blk < 6; blk++) begin
            random_config();
            for (int n = 0; n < 36; n++) send_length($urandom_range(255));
            drain();
         end
      end
      if (board.errors == 0 && board.pending_airtime.size() == 0)
         $display("lora_time_on_air_core_tb: done, clean");
      else
         $display("lora_time_on_air_core_tb: done, errors");
      $finish;
   end
endmodule

### lora_time_on_air_core.f
+incdir+rtl/core
rtl/core/ltoa_pkg.sv
rtl/core/ltoa_div_cell.sv
rtl/core/lora_time_on_air_core.sv
rtl/core/ltoa_checker.sv
dv/lora_time_on_air_core_tb.sv
